// ===== rtl/core/sfp_pkg.sv =====
// Shared types and constants for the ship-date filter and projector.
package sfp_pkg;

  localparam int OUTPUT_PAGES = 1024;
  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_W       = 10;
  localparam int POS_W        = 12;
  localparam int CNT_W        = 32;
  localparam int REC_OUT_B    = 34;
  localparam int PAGE0_HDR    = 4;

  // skid queue between filter and placement
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [PAGE_W-1:0] LAST_PAGE   = PAGE_W'(OUTPUT_PAGES - 1);
  localparam logic [POS_W:0]    PAGE_LIMIT  = (POS_W + 1)'(PAGE_BYTES);
  localparam logic [POS_W-1:0]  REC_STEP    = POS_W'(REC_OUT_B);
  localparam logic [POS_W-1:0]  FIRST_POS   = POS_W'(PAGE0_HDR);

  // projected payload of one passing record
  typedef struct packed {
    logic [15:0] flags;
    logic [63:0] first;
    logic [63:0] second;
    logic [63:0] third;
    logic [63:0] fourth;
  } rec_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [PAGE_W-1:0] page_index;
    logic [POS_W-1:0]  byte_offset;
    rec_t              rec;
    logic [CNT_W-1:0]  pass_total;
    logic              overflow;
  } res_t;

endpackage

// ===== rtl/core/sfp_front.sv =====
// Front end: cutoff register, date compare and push of passing records.
module sfp_front
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_ship_date,
  input  logic [15:0] in_status_flags,
  input  logic [63:0] in_word_at_32,
  input  logic [63:0] in_word_at_16,
  input  logic [63:0] in_word_at_24,
  input  logic [63:0] in_word_at_40,
  output logic        q_push,
  output rec_t        q_wdata,
  input  logic        q_full
);

  logic [63:0] cutoff_r;
  logic [63:0] cutoff_nxt;
  logic        date_ok;

  // first character sits in the low byte; flip so it becomes most significant
  function automatic logic [63:0] byte_rev(input logic [63:0] v);
    logic [63:0] r;
    for (int k = 0; k < 8; k++) begin
      r[8*k +: 8] = v[8*(7-k) +: 8];
    end
    return r;
  endfunction

  assign cutoff_nxt = cfg_wr_en ? cfg_wr_data : cutoff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
    end else begin
      cutoff_r <= cutoff_nxt;
    end
  end

  assign date_ok = byte_rev(in_ship_date) <= byte_rev(cutoff_r);

  assign in_full = q_full;
  assign q_push  = in_push && !q_full && date_ok;

  assign q_wdata.flags  = in_status_flags;
  assign q_wdata.first  = in_word_at_32;
  assign q_wdata.second = in_word_at_16;
  assign q_wdata.third  = in_word_at_24;
  assign q_wdata.fourth = in_word_at_40;

endmodule

// ===== rtl/core/sfp_queue.sv =====
// Short queue of passing records between filter and placement.
module sfp_queue
  import sfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t wdata,
  output logic full,
  output logic valid,
  input  logic pop,
  output rec_t rdata
);

  rec_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = cnt_r == (QAW + 1)'(QDEPTH);
  assign valid   = cnt_r != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  assign wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
  assign rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
  assign cnt_nxt = cnt_r + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata = mem_r[rp_r];

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW + 1)'(QDEPTH))
    else $error("queue count past depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r == rp_r + cnt_r[QAW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/core/sfp_back.sv =====
// Back end: page placement, pass count and the output register.
module sfp_back
  import sfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_pop,
  input  rec_t q_rdata,
  output logic out_empty,
  input  logic out_pop,
  output res_t res
);

  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              vld_r, vld_nxt;
  res_t              res_r, res_nxt;
  logic              load;
  logic [POS_W:0]    pos_end;
  logic              wrap;
  logic              last;

  // output slot free or being drained this cycle
  assign load  = q_valid && (!vld_r || out_pop);
  assign q_pop = load;

  // pos_r is the next write position, header of page zero included
  assign pos_end = {1'b0, pos_r} + {1'b0, REC_STEP};
  assign wrap    = pos_end >= PAGE_LIMIT;
  assign last    = page_r == LAST_PAGE;

  always_comb begin
    page_nxt = page_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    vld_nxt  = vld_r && !out_pop;
    if (load) begin
      vld_nxt             = 1'b1;
      cnt_nxt             = cnt_r + 1'b1;
      res_nxt.rec         = q_rdata;
      res_nxt.pass_total  = cnt_r + 1'b1;
      res_nxt.overflow    = 1'b0;
      res_nxt.page_index  = page_r;
      res_nxt.byte_offset = pos_r;
      if (wrap) begin
        res_nxt.byte_offset = '0;
        if (last) begin
          res_nxt.overflow   = 1'b1;
          res_nxt.page_index = LAST_PAGE;
        end else begin
          page_nxt           = page_r + 1'b1;
          res_nxt.page_index = page_r + 1'b1;
          pos_nxt            = REC_STEP;
        end
      end else begin
        pos_nxt = pos_end[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '0;
      pos_r  <= FIRST_POS;
      cnt_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      page_r <= page_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_empty = !vld_r;
  assign res       = res_r;

  a_ovf_place: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && res_r.overflow) |-> (res_r.byte_offset == '0 && res_r.page_index == LAST_PAGE))
    else $error("overflow result not placed at last page start");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (cnt_r == $past(cnt_r) + 1'b1 && res_r.pass_total == cnt_r))
    else $error("pass count out of step with results");

endmodule

// ===== rtl/core/shipdate_filter_projector_top.sv =====
// Top level of the ship-date filter and projector.
//
//  channel   direction  handshake            transfer when
//  in_*      input      in_push / in_full    in_push && !in_full
//  out_*     output     out_pop / out_empty  out_pop && !out_empty
//  cfg_*     input      cfg_wr_en            cfg_wr_en (cutoff date)
//
// One record per cycle sustained while out_pop keeps up: the date compare
// runs in the cycle the record is taken, and placement plus count update run
// in the cycle a record leaves the four-entry queue into the output register.
// A passing record is written into the queue when taken and then moves into
// the output register, where out_empty falls and it can be popped.
// Failing records are dropped at the input and give no result.
// Synchronous active-low reset clears cutoff, page and count; position starts past the page-zero header.
// A stalled output fills the queue; in_full rises once all four entries wait.
module shipdate_filter_projector_top
  import sfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [63:0]       cfg_wr_data,
  // record input
  input  logic              in_push,
  output logic              in_full,
  input  logic [63:0]       in_ship_date,
  input  logic [15:0]       in_status_flags,
  input  logic [63:0]       in_word_at_32,
  input  logic [63:0]       in_word_at_16,
  input  logic [63:0]       in_word_at_24,
  input  logic [63:0]       in_word_at_40,
  // projected result
  output logic              out_empty,
  input  logic              out_pop,
  output logic [PAGE_W-1:0] out_page_index,
  output logic [POS_W-1:0]  out_byte_offset,
  output logic [15:0]       out_flags,
  output logic [63:0]       out_first,
  output logic [63:0]       out_second,
  output logic [63:0]       out_third,
  output logic [63:0]       out_fourth,
  output logic [CNT_W-1:0]  out_pass_total,
  output logic              out_overflow
);

  logic q_push, q_full, q_valid, q_pop;
  rec_t q_wdata, q_rdata;
  res_t res;

  // filter: compares date against cutoff, pushes passing records
  sfp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_ship_date    (in_ship_date),
    .in_status_flags (in_status_flags),
    .in_word_at_32   (in_word_at_32),
    .in_word_at_16   (in_word_at_16),
    .in_word_at_24   (in_word_at_24),
    .in_word_at_40   (in_word_at_40),
    .q_push          (q_push),
    .q_wdata         (q_wdata),
    .q_full          (q_full)
  );

  // decouples filter from a stalled consumer
  sfp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  // placement and output register
  sfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_page_index  = res.page_index;
  assign out_byte_offset = res.byte_offset;
  assign out_flags       = res.rec.flags;
  assign out_first       = res.rec.first;
  assign out_second      = res.rec.second;
  assign out_third       = res.rec.third;
  assign out_fourth      = res.rec.fourth;
  assign out_pass_total  = res.pass_total;
  assign out_overflow    = res.overflow;

endmodule

// ===== tb/sv/shipdate_filter_projector_top_tb.sv =====
// Self-checking testbench for the ship-date filter and projector top level.
module shipdate_filter_projector_top_tb;
  import sfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog: cycles in a row without any transfer on either channel.
  localparam int STALL_LIMIT = 4000;
  // Long receiver hold-off used to back the block up into in_full.
  localparam int HOLD_CYCLES = 48;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // One record as the feeder presents it.
  typedef struct {
    logic [63:0] ship_date;
    logic [15:0] flags;
    logic [63:0] w32;
    logic [63:0] w16;
    logic [63:0] w24;
    logic [63:0] w40;
  } ship_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_wr_en = 1'b0;
  logic [63:0]       cfg_wr_data = '0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [63:0]       in_ship_date = '0;
  logic [15:0]       in_status_flags = '0;
  logic [63:0]       in_word_at_32 = '0;
  logic [63:0]       in_word_at_16 = '0;
  logic [63:0]       in_word_at_24 = '0;
  logic [63:0]       in_word_at_40 = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [PAGE_W-1:0] out_page_index;
  logic [POS_W-1:0]  out_byte_offset;
  logic [15:0]       out_flags;
  logic [63:0]       out_first;
  logic [63:0]       out_second;
  logic [63:0]       out_third;
  logic [63:0]       out_fourth;
  logic [CNT_W-1:0]  out_pass_total;
  logic              out_overflow;

  shipdate_filter_projector_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_ship_date    (in_ship_date),
    .in_status_flags (in_status_flags),
    .in_word_at_32   (in_word_at_32),
    .in_word_at_16   (in_word_at_16),
    .in_word_at_24   (in_word_at_24),
    .in_word_at_40   (in_word_at_40),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_page_index  (out_page_index),
    .out_byte_offset (out_byte_offset),
    .out_flags       (out_flags),
    .out_first       (out_first),
    .out_second      (out_second),
    .out_third       (out_third),
    .out_fourth      (out_fourth),
    .out_pass_total  (out_pass_total),
    .out_overflow    (out_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state of the block: cutoff register plus output placement.
  // ---------------------------------------------------------------------------
  logic [63:0]      cutoff_q = '0;
  int               page_now = 0;     // output page in use
  int               fill_now = 0;     // bytes used in page, page-zero header excluded
  logic [CNT_W-1:0] pass_cnt = '0;

  ship_rec_t record_q[$];   // records waiting for the driver
  res_t      projected_q[$]; // projected results still to come out

  // bookkeeping
  int n_err = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_ovf_seen = 0;
  int n_cfg = 0;
  int n_full = 0;

  // idling control, set from the stimulus process
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int tx_gap = 0;
  int rx_gap = 0;

  ship_rec_t cur_rec;

  // Dates are strings with the first character in the low byte, so the first
  // character is the most significant: reverse bytes and compare as integers.
  function automatic logic [63:0] date_key(logic [63:0] d);
    logic [63:0] k;
    for (int i = 0; i < 8; i++) k[8*(7-i) +: 8] = d[8*i +: 8];
    return k;
  endfunction

  function automatic logic [63:0] ascii_date(int y, int m, int d);
    int          dig[8];
    logic [63:0] v;
    dig = '{y / 1000 % 10, y / 100 % 10, y / 10 % 10, y % 10, m / 10, m % 10, d / 10, d % 10};
    for (int i = 0; i < 8; i++) v[8*i +: 8] = 8'h30 + 8'(dig[i]);
    return v;
  endfunction

  // Filter one accepted record; a passing record is placed and its projection
  // joins the queue of expected results.
  task automatic filter_and_place(ship_rec_t r);
    int   pos;
    int   page;
    logic ovf;
    res_t e;
    if (date_key(r.ship_date) > date_key(cutoff_q)) return;
    ovf  = 1'b0;
    pos  = fill_now + ((page_now == 0) ? PAGE0_HDR : 0);
    page = page_now;
    if (pos + REC_OUT_B >= PAGE_BYTES) begin
      if (page_now + 1 >= OUTPUT_PAGES) begin
        // out of output pages: report against the last page, state frozen
        ovf  = 1'b1;
        page = OUTPUT_PAGES - 1;
        pos  = 0;
      end else begin
        page_now = page_now + 1;
        fill_now = 0;
        page     = page_now;
        pos      = 0;
      end
    end
    if (!ovf) fill_now = pos + REC_OUT_B - ((page_now == 0) ? PAGE0_HDR : 0);
    pass_cnt = pass_cnt + 1'b1;
    e.page_index  = PAGE_W'(page);
    e.byte_offset = POS_W'(pos);
    e.rec.flags   = r.flags;
    e.rec.first   = r.w32;
    e.rec.second  = r.w16;
    e.rec.third   = r.w24;
    e.rec.fourth  = r.w40;
    e.pass_total  = pass_cnt;
    e.overflow    = ovf;
    projected_q.push_back(e);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers records from record_q, holds them while in_full is high,
  // and inserts random idle bursts when tx idling is on.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      tx_gap  <= 0;
    end else begin
      if (in_push && !in_full) begin
        filter_and_place(cur_rec);
        n_sent++;
      end
      if (in_push && in_full) begin
        n_full++;                       // keep offering the same record
      end else if (tx_gap != 0) begin
        tx_gap  <= tx_gap - 1;
        in_push <= 1'b0;
      end else if (tx_idle_on && $urandom_range(0, 7) == 0) begin
        tx_gap  <= $urandom_range(0, 6);
        in_push <= 1'b0;
      end else if (record_q.size() != 0) begin
        cur_rec = record_q.pop_front();
        in_ship_date    <= cur_rec.ship_date;
        in_status_flags <= cur_rec.flags;
        in_word_at_32   <= cur_rec.w32;
        in_word_at_16   <= cur_rec.w16;
        in_word_at_24   <= cur_rec.w24;
        in_word_at_40   <= cur_rec.w40;
        in_push         <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the driver keeps pushing meanwhile.
  always @(posedge clk) begin
    if (!rst_n) hold_cnt <= 0;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    else if (hold_req) hold_cnt <= HOLD_CYCLES;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each popped result against the oldest projection and
  // drives out_pop with its own random idle bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      out_pop <= 1'b0;
      rx_gap  <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (projected_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result, expected none actual page %0d offset %0d total %0d",
                   $time, out_page_index, out_byte_offset, out_pass_total);
        end else begin
          e = projected_q.pop_front();
          check_field("page_index", 64'(e.page_index), 64'(out_page_index));
          check_field("byte_offset", 64'(e.byte_offset), 64'(out_byte_offset));
          check_field("flags", 64'(e.rec.flags), 64'(out_flags));
          check_field("first", e.rec.first, out_first);
          check_field("second", e.rec.second, out_second);
          check_field("third", e.rec.third, out_third);
          check_field("fourth", e.rec.fourth, out_fourth);
          check_field("pass_total", 64'(e.pass_total), 64'(out_pass_total));
          check_field("overflow", 64'(e.overflow), 64'(out_overflow));
          if (e.overflow) n_ovf_seen++;
          n_checked++;
        end
      end
      if (hold_cnt != 0) begin
        out_pop <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap  <= rx_gap - 1;
        out_pop <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        rx_gap  <= $urandom_range(0, 6);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer restarts the count.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic ship_rec_t make_record(logic [63:0] date, logic [15:0] flags,
                                            logic [63:0] w32, logic [63:0] w16,
                                            logic [63:0] w24, logic [63:0] w40);
    ship_rec_t r;
    r.ship_date = date;
    r.flags     = flags;
    r.w32       = w32;
    r.w16       = w16;
    r.w24       = w24;
    r.w40       = w40;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random record; the date is mostly a random 1990s date and sometimes equals
  // or nearly equals the current cutoff, so both outcomes of the compare are common.
  function automatic ship_rec_t random_record();
    logic [63:0] d;
    int          k;
    case ($urandom_range(0, 9))
      0: d = rand64();
      1: d = cutoff_q;
      2: begin
        // cutoff off by one in a single character, either direction
        d = cutoff_q;
        k = $urandom_range(0, 7);
        d[8*k +: 8] = d[8*k +: 8] + ($urandom_range(0, 1) ? 8'h01 : 8'hFF);
      end
      default: d = ascii_date($urandom_range(1992, 1999), $urandom_range(1, 12),
                              $urandom_range(1, 31));
    endcase
    return make_record(d, 16'($urandom), rand64(), rand64(), rand64(), rand64());
  endfunction

  // Wait until nothing is in flight, then give dropped records time to clear.
  task automatic wait_drained();
    while (record_q.size() != 0 || in_push || projected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cutoff(logic [63:0] v);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cutoff_q = v;
    n_cfg++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_segment(int count, bit idle);
    tx_idle_on = idle;
    rx_idle_on = idle;
    for (int i = 0; i < count; i++) record_q.push_back(random_record());
  endtask

  initial begin
    logic [63:0] cut;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: cutoff still at its reset value of all zero bytes.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    record_q.push_back(make_record('0, '0, '0, '0, '0, '0));
    record_q.push_back(make_record(ALL_ONES, 16'hFFFF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    record_q.push_back(make_record(64'h1, 16'h1234, rand64(), rand64(), rand64(), rand64()));
    record_q.push_back(make_record('0, 16'hFFFF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));

    // Directed: a realistic cutoff, dates around it in each position.
    cut = ascii_date(1998, 9, 2);
    write_cutoff(cut);
    record_q.push_back(make_record(cut, 16'h5555, rand64(), rand64(), rand64(), rand64()));
    record_q.push_back(make_record(ascii_date(1998, 9, 1), 16'hAAAA, rand64(), rand64(),
                                   rand64(), rand64()));
    record_q.push_back(make_record(ascii_date(1998, 9, 3), '0, rand64(), rand64(),
                                   rand64(), rand64()));
    record_q.push_back(make_record(ascii_date(1998, 10, 2), '0, rand64(), rand64(),
                                   rand64(), rand64()));
    record_q.push_back(make_record(ascii_date(1998, 8, 31), 16'h0F0F, rand64(), rand64(),
                                   rand64(), rand64()));
    record_q.push_back(make_record(ascii_date(1997, 12, 31), 16'hF0F0, rand64(), rand64(),
                                   rand64(), rand64()));
    record_q.push_back(make_record(ascii_date(1999, 1, 1), '0, rand64(), rand64(),
                                   rand64(), rand64()));
    record_q.push_back(make_record(ascii_date(2000, 1, 1), '0, rand64(), rand64(),
                                   rand64(), rand64()));
    // non-digit last character: ':' sorts above '2', '/' below it
    record_q.push_back(make_record({8'h3A, cut[55:0]}, 16'h8001, rand64(), rand64(),
                                   rand64(), rand64()));
    record_q.push_back(make_record({8'h2F, cut[55:0]}, 16'h0180, rand64(), rand64(),
                                   rand64(), rand64()));

    // Directed: top cutoff lets everything through.
    write_cutoff(ALL_ONES);
    record_q.push_back(make_record(ALL_ONES, 16'h5555, {4{16'h5555}}, {4{16'hAAAA}},
                                   {4{16'h5555}}, {4{16'hAAAA}}));
    record_q.push_back(make_record('0, 16'hAAAA, {4{16'hAAAA}}, {4{16'h5555}},
                                   {4{16'hAAAA}}, {4{16'h5555}}));
    record_q.push_back(random_record());

    // Random segments, each under its own cutoff; one runs without idling.
    write_cutoff(ascii_date($urandom_range(1993, 1998), $urandom_range(1, 12),
                            $urandom_range(1, 31)));
    random_segment(200, 1'b1);
    write_cutoff(ALL_ONES);
    random_segment(200, 1'b1);
    write_cutoff('0);
    random_segment(200, 1'b0);
    write_cutoff(rand64());
    random_segment(100, 1'b1);
    write_cutoff(ascii_date($urandom_range(1993, 1998), $urandom_range(1, 12),
                            $urandom_range(1, 31)));
    random_segment(100, 1'b1);

    // Back-pressure: receiver holds off while every record passes, so the
    // internal queue fills and in_full has to rise. No idling from here.
    write_cutoff(ALL_ONES);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < 24; i++) record_q.push_back(random_record());
    hold_req = 1'b1;
    while (hold_cnt == 0) @(negedge clk);
    hold_req = 1'b0;

    // A last mixed batch at full rate on both sides.
    write_cutoff(ascii_date(1996, $urandom_range(1, 12), $urandom_range(1, 31)));
    random_segment(30, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d records over %0d cutoff settings; %0d results checked, %0d past the last page.",
             n_sent, n_cfg + 1, n_checked, n_ovf_seen);
    $display("Input held off by in_full for %0d cycles; %0d results never arrived.",
             n_full, projected_q.size());
    if (n_err == 0 && projected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
